/* design/pmtsp_pkg.sv */
// ----------------------------------------------------------------------------
// pmtsp_pkg
// Record kinds and the record type shared by the program map section parser.
// ----------------------------------------------------------------------------
`default_nettype none

package pmtsp_pkg;

    typedef enum logic [2:0] {
        KIND_HEADER      = 3'd0,
        KIND_PROG_DESC   = 3'd1,
        KIND_STREAM      = 3'd2,
        KIND_STREAM_DESC = 3'd3,
        KIND_CRC         = 3'd4,
        KIND_ERROR       = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t        record_kind;
        logic [15:0]  program_id;
        logic [4:0]   version;
        logic         current_next;
        logic [7:0]   section_index;
        logic [7:0]   final_section_index;
        logic [12:0]  clock_ref_pid;
        logic [7:0]   stream_kind;
        logic [12:0]  es_pid;
        logic [11:0]  length_value;
        logic [7:0]   descriptor_tag;
        logic [31:0]  crc_value;
    } record_t;

endpackage

`default_nettype wire

/* design/pmt_section_parser_core.sv */
// ----------------------------------------------------------------------------
// pmt_section_parser_core
// Parses a program map section one byte per request and emits header,
// descriptor, stream entry, crc and error records.
// a record appears on m_tvalid in the cycle after its byte is accepted
// throughput: one byte per cycle while the output register is empty or m_tready is high
// a byte is taken while a record waits, as long as m_tready frees the output register
// reset clears the parse state and the output valid; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_section_parser_core #(
    parameter int MAX_SECTION_BYTES = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [23:0]   s_tdata,   // byte_value, section_bytes, zero pad
    input  wire logic          s_tuser,   // first_byte
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [127:0]       m_tdata,   // program_id, version, current_next, section_index,
                                          // final_section_index, clock_ref_pid, stream_kind,
                                          // es_pid, length_value, descriptor_tag,
                                          // crc_value, zero pad
    output logic [2:0]         m_tuser    // record_kind
);

    logic                 s_accept;
    logic                 rec_valid;
    pmtsp_pkg::record_t   rec;
    logic                 m_valid_reg;
    pmtsp_pkg::record_t   m_rec_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    pmtsp_engine #(
        .MAX_SECTION_BYTES (MAX_SECTION_BYTES)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .byte_value    (s_tdata[7:0]),
        .first_byte    (s_tuser),
        .section_bytes (s_tdata[18:8]),
        .rec_valid     (rec_valid),
        .rec           (rec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= rec_valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && rec_valid) begin
            m_rec_reg <= rec;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_rec_reg.record_kind;
    assign m_tdata  = {4'd0,
                       m_rec_reg.crc_value,
                       m_rec_reg.descriptor_tag,
                       m_rec_reg.length_value,
                       m_rec_reg.es_pid,
                       m_rec_reg.stream_kind,
                       m_rec_reg.clock_ref_pid,
                       m_rec_reg.final_section_index,
                       m_rec_reg.section_index,
                       m_rec_reg.current_next,
                       m_rec_reg.version,
                       m_rec_reg.program_id};

endmodule

`default_nettype wire

/* design/pmtsp_engine.sv */
// ----------------------------------------------------------------------------
// pmtsp_engine
// Byte-wise parse state of one program map section; yields at most one
// record for each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pmtsp_engine #(
    parameter int MAX_SECTION_BYTES = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic [7:0]        byte_value,
    input  wire logic              first_byte,
    input  wire logic [10:0]       section_bytes,
    output logic                   rec_valid,
    output pmtsp_pkg::record_t     rec
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_HDR, PH_TAG, PH_LEN, PH_BODY, PH_SHDR, PH_ERR_NEXT, PH_SKIP, PH_CRC
    } phase_t;

    localparam logic [10:0] MinSection = 11'd16;
    localparam logic [10:0] CrcBytes   = 11'd4;
    localparam logic [10:0] LatchFirst = 11'd3;
    localparam logic [10:0] LatchLast  = 11'd7;
    localparam logic [10:0] FieldFirst = 11'd8;
    localparam logic [10:0] HeaderLast = 11'd11;
    localparam logic [11:0] EntryHead  = 12'd4;

    phase_t       phase_reg, phase_next;
    logic [10:0]  pos_reg, pos_next;
    logic [10:0]  total_reg, total_next;
    logic [11:0]  ibl_reg, ibl_next;
    logic [7:0]   dbl_reg, dbl_next;
    logic         stream_reg, stream_next;
    logic [31:0]  fa_reg, fa_next;
    logic [39:0]  hl_reg, hl_next;

    logic [10:0]  crc_start;
    logic [31:0]  fa_shift;
    logic [11:0]  ibl_dec;
    logic [7:0]   dbl_dec;
    logic         do_enter;
    logic         enter_stream;
    logic [11:0]  enter_len;
    logic [12:0]  enter_end;
    logic         bad_total;

    always_comb begin
        crc_start = total_reg - CrcBytes;
        fa_shift  = {fa_reg[23:0], byte_value};
        ibl_dec   = (ibl_reg == 12'd0) ? 12'd0 : ibl_reg - 12'd1;
        dbl_dec   = (dbl_reg == 8'd0) ? 8'd0 : dbl_reg - 8'd1;
        bad_total = (section_bytes < MinSection) ||
                    ({21'd0, section_bytes} > 32'(MAX_SECTION_BYTES));

        phase_next   = phase_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        ibl_next     = ibl_reg;
        dbl_next     = dbl_reg;
        stream_next  = stream_reg;
        fa_next      = fa_reg;
        hl_next      = hl_reg;
        rec_valid    = 1'b0;
        rec          = '0;
        do_enter     = 1'b0;
        enter_stream = 1'b0;
        enter_len    = 12'd0;
        enter_end    = 13'd0;

        if (accept) begin
            if (first_byte) begin
                total_next  = section_bytes;
                ibl_next    = 12'd0;
                dbl_next    = 8'd0;
                stream_next = 1'b0;
                if (bad_total) begin
                    phase_next      = PH_IDLE;
                    pos_next        = 11'd0;
                    rec_valid       = 1'b1;
                    rec.record_kind = pmtsp_pkg::KIND_ERROR;
                end else begin
                    phase_next = PH_HDR;
                    pos_next   = 11'd1;
                end
            end else if (phase_reg != PH_IDLE) begin
                pos_next = pos_reg + 11'd1;
                if (phase_reg == PH_HDR) begin
                    if (pos_reg >= LatchFirst && pos_reg <= LatchLast) begin
                        hl_next = {hl_reg[31:0], byte_value};
                    end else if (pos_reg >= FieldFirst) begin
                        fa_next = fa_shift;
                    end
                    if (pos_reg == HeaderLast) begin
                        rec_valid               = 1'b1;
                        rec.record_kind         = pmtsp_pkg::KIND_HEADER;
                        rec.program_id          = hl_reg[39:24];
                        rec.version             = hl_reg[21:17];
                        rec.current_next        = hl_reg[16];
                        rec.section_index       = hl_reg[15:8];
                        rec.final_section_index = hl_reg[7:0];
                        rec.clock_ref_pid       = fa_shift[28:16];
                        rec.length_value        = fa_shift[11:0];
                        do_enter                = 1'b1;
                        enter_stream            = 1'b0;
                        enter_len               = fa_shift[11:0];
                    end
                end else if (pos_reg >= crc_start) begin
                    fa_next = fa_shift;
                    if (pos_reg == crc_start) begin
                        phase_next = PH_CRC;
                    end
                    if (({1'b0, pos_reg} + 12'd1) == {1'b0, total_reg}) begin
                        phase_next      = PH_IDLE;
                        rec_valid       = 1'b1;
                        rec.record_kind = pmtsp_pkg::KIND_CRC;
                        rec.crc_value   = fa_shift;
                    end else if (pos_reg == crc_start && phase_reg != PH_SKIP &&
                                 !(phase_reg == PH_SHDR && ibl_reg == 12'd0)) begin
                        rec_valid       = 1'b1;
                        rec.record_kind = pmtsp_pkg::KIND_ERROR;
                    end
                end else begin
                    case (phase_reg)
                        PH_ERR_NEXT: begin
                            rec_valid       = 1'b1;
                            rec.record_kind = pmtsp_pkg::KIND_ERROR;
                            phase_next      = PH_SKIP;
                        end
                        PH_SHDR: begin
                            if (ibl_reg < EntryHead) begin
                                fa_next  = fa_shift;
                                ibl_next = ibl_reg + 12'd1;
                            end else begin
                                rec_valid          = 1'b1;
                                rec.record_kind    = pmtsp_pkg::KIND_STREAM;
                                rec.stream_kind    = fa_reg[31:24];
                                rec.es_pid         = {fa_reg[20:16], fa_reg[15:8]};
                                rec.length_value   = {fa_reg[3:0], byte_value};
                                ibl_next           = 12'd0;
                                do_enter           = 1'b1;
                                enter_stream       = 1'b1;
                                enter_len          = {fa_reg[3:0], byte_value};
                            end
                        end
                        PH_TAG: begin
                            ibl_next = ibl_dec;
                            fa_next  = fa_shift;
                            if (ibl_dec == 12'd0) begin
                                phase_next = PH_SHDR;
                            end else begin
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            ibl_next           = ibl_dec;
                            rec_valid          = 1'b1;
                            rec.record_kind    = stream_reg ? pmtsp_pkg::KIND_STREAM_DESC
                                                            : pmtsp_pkg::KIND_PROG_DESC;
                            rec.length_value   = {4'd0, byte_value};
                            rec.descriptor_tag = fa_reg[7:0];
                            dbl_next           = byte_value;
                            if (ibl_dec == 12'd0) begin
                                phase_next = PH_SHDR;
                            end else if (byte_value == 8'd0) begin
                                phase_next = PH_TAG;
                            end else begin
                                phase_next = PH_BODY;
                            end
                        end
                        PH_BODY: begin
                            ibl_next = ibl_dec;
                            dbl_next = dbl_dec;
                            if (ibl_dec == 12'd0) begin
                                phase_next = PH_SHDR;
                            end else if (dbl_dec == 8'd0) begin
                                phase_next = PH_TAG;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                if (do_enter) begin
                    stream_next = enter_stream;
                    enter_end   = {2'd0, pos_reg} + 13'd1 + {1'b0, enter_len};
                    if (enter_end > {2'd0, crc_start}) begin
                        phase_next = PH_ERR_NEXT;
                    end else if (enter_len == 12'd0) begin
                        phase_next = PH_SHDR;
                        ibl_next   = 12'd0;
                    end else begin
                        phase_next = PH_TAG;
                        ibl_next   = enter_len;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= 11'd0;
            total_reg  <= 11'd0;
            ibl_reg    <= 12'd0;
            dbl_reg    <= 8'd0;
            stream_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            ibl_reg    <= ibl_next;
            dbl_reg    <= dbl_next;
            stream_reg <= stream_next;
        end
    end

    always_ff @(posedge aclk) begin
        fa_reg <= fa_next;
        hl_reg <= hl_next;
    end

endmodule

`default_nettype wire
